// ----- rtl/lsrf_pkg.sv -----
// Package for the serial reply frame parser: shared types, register indexes
// and sizing constants. No dependencies.
`default_nettype none

package lsrf_pkg;

	// Largest payload a frame may announce, in bytes (legal range 8 to 128)
	localparam int BUFFER_BYTES = 128;

	// A variable read announces words, so a byte count spans nine bits
	localparam int COUNT_W = 9;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_READ_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VAR_READ_CODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_FRAMING = 3'd4;

	// Frame kinds
	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_VARIABLE = 1'b1;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] register_read_code;
		logic [7:0] variable_read_code;
		logic       short_framing;
	} cfg_t;

	typedef struct packed {
		logic        frame_kind;
		logic [15:0] item_address;
		logic [7:0]  payload_byte;
		logic [6:0]  payload_index;
		logic        final_byte;
	} result_t;

	// Parser status seen by the top level checks
	typedef struct packed {
		logic idle;
		logic in_data;
	} parse_status_t;

endpackage : lsrf_pkg

`default_nettype wire

// ----- rtl/lsrf_cfg_regs.sv -----
// Configuration register file of the serial reply frame parser.
// Depends on lsrf_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module lsrf_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lsrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output      lsrf_pkg::cfg_t                cfg
);
	import lsrf_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first       <= 8'h5A;
			cfg_q.header_second      <= 8'hA5;
			cfg_q.register_read_code <= 8'h81;
			cfg_q.variable_read_code <= 8'h83;
			cfg_q.short_framing      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_FIRST:  cfg_q.header_first       <= cfg_data;
				CFG_HEADER_SECOND: cfg_q.header_second      <= cfg_data;
				CFG_REG_READ_CODE: cfg_q.register_read_code <= cfg_data;
				CFG_VAR_READ_CODE: cfg_q.variable_read_code <= cfg_data;
				CFG_SHORT_FRAMING: cfg_q.short_framing      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule : lsrf_cfg_regs

`default_nettype wire

// ----- rtl/lsrf_parser.sv -----
// Frame recognition state machine: walks header, command, address and count
// fields and emits one result per data byte. Depends on lsrf_pkg.
`default_nettype none

module lsrf_parser (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    fire,
	input  wire logic [7:0]              rx_byte,
	input  wire lsrf_pkg::cfg_t          cfg,
	output      logic                    res_valid,
	output      lsrf_pkg::result_t       res,
	output      lsrf_pkg::parse_status_t status
);
	import lsrf_pkg::*;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_HEAD1   = 3'd1;
	localparam logic [2:0] PH_LENGTH  = 3'd2;
	localparam logic [2:0] PH_COMMAND = 3'd3;
	localparam logic [2:0] PH_FIELDS  = 3'd4;
	localparam logic [2:0] PH_DATA    = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  fcnt_q, fcnt_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  rem_q, rem_d;
	logic        kind_q, kind_d;

	logic [COUNT_W-1:0] count_bytes;
	logic               count_bad;
	logic [COUNT_W-1:0] count_less;

	// Byte count of the frame: words are doubled for variable reads
	always_comb begin
		count_bytes = (kind_q == KIND_VARIABLE) ? {rx_byte, 1'b0} : {1'b0, rx_byte};
		count_bad   = (count_bytes == '0) || (count_bytes > COUNT_W'(BUFFER_BYTES));
		count_less  = count_bytes - COUNT_W'(1);
	end

	// Next state for the transaction on the input
	always_comb begin
		phase_d = phase_q;
		fcnt_d  = fcnt_q;
		addr_d  = addr_q;
		rem_d   = rem_q;
		kind_d  = kind_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (rx_byte == cfg.header_first) begin
					phase_d = PH_HEAD1;
				end else begin
					fcnt_d = '0;
				end
			end
			PH_HEAD1: begin
				if (cfg.short_framing) begin
					if (rx_byte == cfg.variable_read_code) begin
						kind_d  = KIND_VARIABLE;
						fcnt_d  = '0;
						phase_d = PH_FIELDS;
					end else begin
						phase_d = PH_IDLE;
						fcnt_d  = '0;
					end
				end else if (rx_byte == cfg.header_second) begin
					phase_d = PH_LENGTH;
				end else begin
					phase_d = PH_IDLE;
					fcnt_d  = '0;
				end
			end
			PH_LENGTH: begin
				phase_d = PH_COMMAND;
			end
			PH_COMMAND: begin
				// Register read wins when both codes match
				if (rx_byte == cfg.register_read_code) begin
					kind_d  = KIND_REGISTER;
					fcnt_d  = '0;
					phase_d = PH_FIELDS;
				end else if (rx_byte == cfg.variable_read_code) begin
					kind_d  = KIND_VARIABLE;
					fcnt_d  = '0;
					phase_d = PH_FIELDS;
				end else begin
					phase_d = PH_IDLE;
					fcnt_d  = '0;
				end
			end
			PH_FIELDS: begin
				if (fcnt_q == 8'd0) begin
					addr_d = {8'h00, rx_byte};
					fcnt_d = 8'd1;
				end else if (kind_q == KIND_VARIABLE && fcnt_q == 8'd1) begin
					addr_d = {addr_q[7:0], rx_byte};
					fcnt_d = 8'd2;
				end else if (count_bad) begin
					// Drop empty or oversized frames
					phase_d = PH_IDLE;
					fcnt_d  = '0;
				end else begin
					rem_d   = count_less[7:0];
					fcnt_d  = '0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rem_q == 8'd0) begin
					phase_d = PH_IDLE;
					fcnt_d  = '0;
				end else begin
					rem_d  = rem_q - 8'd1;
					fcnt_d = fcnt_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				fcnt_d  = '0;
			end
		endcase
	end

	// Advance the parse state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fcnt_q  <= '0;
			addr_q  <= '0;
			rem_q   <= '0;
			kind_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			fcnt_q  <= fcnt_d;
			addr_q  <= addr_d;
			rem_q   <= rem_d;
			kind_q  <= kind_d;
		end
	end

	// Every data byte yields one result
	always_comb begin
		res_valid         = (phase_q == PH_DATA);
		res.frame_kind    = kind_q;
		res.item_address  = addr_q;
		res.payload_byte  = rx_byte;
		res.payload_index = fcnt_q[6:0];
		res.final_byte    = (rem_q == 8'd0);
	end

	assign status.idle    = (phase_q == PH_IDLE);
	assign status.in_data = (phase_q == PH_DATA);

endmodule : lsrf_parser

`default_nettype wire

// ----- rtl/lsrf_out_reg.sv -----
// Result register of the serial reply frame parser: holds one result until
// the receiver takes it. Depends on lsrf_pkg for result_t.
`default_nettype none

module lsrf_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire lsrf_pkg::result_t res,
	input  wire logic              out_ready,
	output      logic              out_valid,
	output      logic              can_load,
	output      lsrf_pkg::result_t out_res
);
	import lsrf_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Space exists when empty or when the held result leaves this cycle
	assign can_load = !valid_q || out_ready;

	// Hold the result until the receiver completes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule : lsrf_out_reg

`default_nettype wire

// ----- rtl/lcd_serial_reply_frame_parser.sv -----
// Serial reply frame parser, top level: ties configuration registers,
// frame state machine and result register together. Depends on lsrf_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready, rx_byte) carries bytes received from
//    the panel's serial link, one byte per transaction.
//  - Output channel (out_valid/out_ready) carries one result per data byte
//    of a register read or variable read reply: kind, address, byte, index
//    within the payload and a final mark on the frame's last byte.
//  - Header, length, command, address and count bytes produce no result.
//  - A data byte shows on the output in the cycle after it is taken.
//  - Throughput: one byte per cycle while results are taken; the frame state
//    machine decides each byte on acceptance; the result register sets the pace.
//  - A stalled receiver holds the result register; in_ready then drops
//    until the result leaves, so no byte is taken that would lose a result.
//  - Reset restores the configuration defaults (0x5A, 0xA5, 0x81, 0x83, long
//    framing) and puts the parser in idle, waiting for the first header.
//  - Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//    write them only while no frame is in flight.
`default_nettype none

module lcd_serial_reply_frame_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [7:0]                    rx_byte,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic                          frame_kind,
	output      logic [15:0]                   item_address,
	output      logic [7:0]                    payload_byte,
	output      logic [6:0]                    payload_index,
	output      logic                          final_byte,
	input  wire logic                          cfg_we,
	input  wire logic [lsrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);
	import lsrf_pkg::*;

	cfg_t          cfg;
	result_t       res;
	result_t       out_res;
	parse_status_t status;
	logic          res_valid;
	logic          can_load;
	logic          in_fire;

	// Accept a byte whenever the result register has room
	assign in_ready = can_load;
	assign in_fire  = in_valid && can_load;

	lsrf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsrf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res),
		.status    (status)
	);

	lsrf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire && res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.can_load  (can_load),
		.out_res   (out_res)
	);

	// Drive the result fields
	assign frame_kind    = out_res.frame_kind;
	assign item_address  = out_res.item_address;
	assign payload_byte  = out_res.payload_byte;
	assign payload_index = out_res.payload_index;
	assign final_byte    = out_res.final_byte;

`ifndef SYNTHESIS
	// The last data byte of a frame returns the parser to idle
	a_final_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res_valid && res.final_byte |=> status.idle)
		else $error("parser not idle after final payload byte");

	// A result is only produced from the data phase
	a_result_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status.in_data && !status.idle)
		else $error("result produced outside the data phase");

	// A stalled result blocks new input so nothing is overwritten
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while a stalled result is held");
`endif

endmodule : lcd_serial_reply_frame_parser

`default_nettype wire

// ----- dv/lcd_serial_reply_frame_parser_test.sv -----
// Testbench for the serial reply frame parser: drives received bytes and
// configuration writes, predicts every payload result and checks it.
// Depends on lsrf_pkg and lcd_serial_reply_frame_parser.
`timescale 1ns / 1ps

module lcd_serial_reply_frame_parser_test;
	import lsrf_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 3;
	localparam int unsigned WATCHDOG_LIMIT = 500;
	localparam int unsigned RANDOM_BYTES   = 1500;
	localparam int unsigned PHASE_BYTES    = 150;
	localparam int unsigned FULL_FRAME     = 1000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
	localparam cfg_t POWER_ON_SETTINGS = {8'h5A, 8'hA5, 8'h81, 8'h83, 1'b0};

	typedef enum logic [2:0] {
		AWAIT_HEAD, AWAIT_SECOND, SKIP_LENGTH, AWAIT_COMMAND, TAKE_FIELDS, TAKE_DATA
	} parse_phase_t;

	typedef enum logic {TXN_RX_BYTE, TXN_SETTING} link_op_t;

	typedef struct {
		link_op_t              op;
		logic [CFG_IDX_W-1:0]  index;
		logic [7:0]            value;
	} link_txn_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 frame_kind;
	logic [15:0]          item_address;
	logic [7:0]           payload_byte;
	logic [6:0]           payload_index;
	logic                 final_byte;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = 8'h00;

	// Stimulus plan and the settings it was built against
	link_txn_t   link_plan[$];
	cfg_t        plan_cfg = POWER_ON_SETTINGS;
	int unsigned bytes_queued = 0;

	// Frame decoder mirror and the payload results it still owes
	cfg_t         cfg_now;
	parse_phase_t phase;
	logic [7:0]   field_cnt;
	logic [15:0]  addr;
	logic [7:0]   remaining;
	logic         kind;
	result_t      due_payload[$];

	int          mismatch_count = 0;
	int          since_accept = 0;
	logic        byte_taken = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned send_pause = 0;
	int unsigned calm_in = 0;
	int unsigned hold_left = 0;
	int unsigned calm_out = 0;

	lcd_serial_reply_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_kind(frame_kind),
		.item_address(item_address),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.final_byte(final_byte),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic cfg_t with_setting(cfg_t c, logic [CFG_IDX_W-1:0] idx,
			logic [7:0] val);
		cfg_t n;
		n = c;
		case (idx)
			CFG_HEADER_FIRST: n.header_first = val;
			CFG_HEADER_SECOND: n.header_second = val;
			CFG_REG_READ_CODE: n.register_read_code = val;
			CFG_VAR_READ_CODE: n.variable_read_code = val;
			CFG_SHORT_FRAMING: n.short_framing = val[0];
			default: ;
		endcase
		return n;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [7:0] pick_setting_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'h00;
		else if (r < 30)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly small legal counts, a few large, a few that drop the frame
	function automatic logic [7:0] pick_count(logic k);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 8'((k == KIND_VARIABLE) ? $urandom_range(1, 4) : $urandom_range(1, 8));
		else if (r < 93)
			return 8'((k == KIND_VARIABLE) ? $urandom_range(5, BUFFER_BYTES / 2)
				: $urandom_range(9, BUFFER_BYTES));
		else if (r < 96)
			return 8'd0;
		return 8'((k == KIND_VARIABLE) ? $urandom_range(BUFFER_BYTES / 2 + 1, 255)
			: $urandom_range(BUFFER_BYTES + 1, 255));
	endfunction

	function automatic logic [15:0] pick_address();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		link_txn_t t;
		t.op = TXN_RX_BYTE;
		t.index = '0;
		t.value = b;
		link_plan.push_back(t);
		bytes_queued++;
	endtask

	task automatic queue_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		link_txn_t t;
		t.op = TXN_SETTING;
		t.index = idx;
		t.value = val;
		link_plan.push_back(t);
		plan_cfg = with_setting(plan_cfg, idx, val);
	endtask

	// Build one reply frame for the planned settings; keep only its first bytes
	task automatic queue_frame(input logic k, input logic [15:0] a, input logic [7:0] count,
			input int unsigned keep);
		logic [7:0]  frame_bytes[$];
		logic        eff_kind;
		logic        parses;
		int unsigned n_data;
		eff_kind = k;
		parses = 1'b1;
		frame_bytes.push_back(plan_cfg.header_first);
		if (plan_cfg.short_framing) begin
			frame_bytes.push_back(k == KIND_VARIABLE ? plan_cfg.variable_read_code
				: plan_cfg.register_read_code);
			if (frame_bytes[1] != plan_cfg.variable_read_code)
				parses = 1'b0;
			eff_kind = KIND_VARIABLE;
		end else begin
			if (plan_cfg.register_read_code == plan_cfg.variable_read_code)
				eff_kind = KIND_REGISTER;
			frame_bytes.push_back(plan_cfg.header_second);
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			frame_bytes.push_back(eff_kind == KIND_VARIABLE ? plan_cfg.variable_read_code
				: plan_cfg.register_read_code);
		end
		if (parses) begin
			if (eff_kind == KIND_VARIABLE)
				frame_bytes.push_back(a[15:8]);
			frame_bytes.push_back(a[7:0]);
			frame_bytes.push_back(count);
			n_data = (eff_kind == KIND_VARIABLE) ? 2 * count : count;
			if (n_data >= 1 && n_data <= BUFFER_BYTES)
				for (int unsigned i = 0; i < n_data; i++)
					frame_bytes.push_back($urandom_range(0, 9) == 0 ? plan_cfg.header_first
						: 8'($urandom_range(0, 255)));
		end
		foreach (frame_bytes[i])
			if (i < keep)
				queue_byte(frame_bytes[i]);
	endtask

	task automatic queue_random_settings();
		logic [7:0] reg_code;
		logic [7:0] var_code;
		reg_code = pick_setting_byte();
		var_code = pick_setting_byte();
		if ($urandom_range(0, 4) == 0)
			reg_code = var_code;
		queue_setting(CFG_HEADER_FIRST, pick_setting_byte());
		queue_setting(CFG_HEADER_SECOND, pick_setting_byte());
		queue_setting(CFG_REG_READ_CODE, reg_code);
		queue_setting(CFG_VAR_READ_CODE, var_code);
		queue_setting(CFG_SHORT_FRAMING, {7'($urandom_range(0, 127)),
			$urandom_range(0, 2) == 0});
	endtask

	task automatic enter_idle();
		phase = AWAIT_HEAD;
		field_cnt = 8'd0;
	endtask

	task automatic open_fields(input logic k);
		kind = k;
		field_cnt = 8'd0;
		phase = TAKE_FIELDS;
	endtask

	// A count of zero or beyond the buffer drops the frame
	task automatic take_count(input int unsigned n);
		if (n == 0 || n > BUFFER_BYTES) begin
			enter_idle();
		end else begin
			remaining = 8'(n - 1);
			field_cnt = 8'd0;
			phase = TAKE_DATA;
		end
	endtask

	// Advance the frame decoder by one received byte
	task automatic parse_reply_byte(input logic [7:0] b);
		result_t r;
		case (phase)
			AWAIT_HEAD: begin
				if (b == cfg_now.header_first)
					phase = AWAIT_SECOND;
				else
					enter_idle();
			end
			AWAIT_SECOND: begin
				if (cfg_now.short_framing) begin
					if (b == cfg_now.variable_read_code)
						open_fields(KIND_VARIABLE);
					else
						enter_idle();
				end else if (b == cfg_now.header_second) begin
					phase = SKIP_LENGTH;
				end else begin
					enter_idle();
				end
			end
			SKIP_LENGTH: phase = AWAIT_COMMAND;
			AWAIT_COMMAND: begin
				if (b == cfg_now.register_read_code)
					open_fields(KIND_REGISTER);
				else if (b == cfg_now.variable_read_code)
					open_fields(KIND_VARIABLE);
				else
					enter_idle();
			end
			TAKE_FIELDS: begin
				if (field_cnt == 8'd0) begin
					addr = {8'h00, b};
					field_cnt = 8'd1;
				end else if (kind == KIND_REGISTER) begin
					take_count(int'(b));
				end else if (field_cnt == 8'd1) begin
					addr = {addr[7:0], b};
					field_cnt = 8'd2;
				end else begin
					take_count(2 * int'(b));
				end
			end
			TAKE_DATA: begin
				r.frame_kind = kind;
				r.item_address = addr;
				r.payload_byte = b;
				r.payload_index = field_cnt[6:0];
				r.final_byte = (remaining == 8'd0);
				due_payload.push_back(r);
				if (remaining == 8'd0) begin
					enter_idle();
				end else begin
					remaining = remaining - 8'd1;
					field_cnt = field_cnt + 8'd1;
				end
			end
			default: enter_idle();
		endcase
	endtask

	task automatic check_payload();
		result_t want;
		if (due_payload.size() == 0) begin
			$error("unexpected result: payload_byte 0x%02h", payload_byte);
			mismatch_count++;
		end else begin
			want = due_payload.pop_front();
			if (frame_kind !== want.frame_kind) begin
				$error("frame_kind: expected %0d, got %0d", want.frame_kind, frame_kind);
				mismatch_count++;
			end
			if (item_address !== want.item_address) begin
				$error("item_address: expected 0x%04h, got 0x%04h", want.item_address,
					item_address);
				mismatch_count++;
			end
			if (payload_byte !== want.payload_byte) begin
				$error("payload_byte: expected 0x%02h, got 0x%02h", want.payload_byte,
					payload_byte);
				mismatch_count++;
			end
			if (payload_index !== want.payload_index) begin
				$error("payload_index: expected %0d, got %0d", want.payload_index,
					payload_index);
				mismatch_count++;
			end
			if (final_byte !== want.final_byte) begin
				$error("final_byte: expected %0d, got %0d", want.final_byte, final_byte);
				mismatch_count++;
			end
		end
	endtask

	// Driver: present bytes with random gaps, write settings once the pipe is empty
	always @(negedge clk) begin
		if (arst_n) begin
			cfg_we = 1'b0;
			if (byte_taken)
				in_valid = 1'b0;
			if (!in_valid && link_plan.size() > 0) begin
				if (link_plan[0].op == TXN_SETTING) begin
					if (due_payload.size() == 0 && !out_valid && since_accept >= SETTLE_CYCLES)
						begin
						cfg_we = 1'b1;
						cfg_index = link_plan[0].index;
						cfg_data = link_plan[0].value;
						void'(link_plan.pop_front());
					end
				end else if (send_pause > 0) begin
					send_pause--;
				end else begin
					rx_byte = link_plan[0].value;
					in_valid = 1'b1;
					void'(link_plan.pop_front());
					if (calm_in > 0) begin
						calm_in--;
						send_pause = 0;
					end else begin
						send_pause = pick_pause();
						if ($urandom_range(0, 149) == 0)
							calm_in = $urandom_range(40, 150);
					end
				end
			end
		end
	end

	// Receiver: stall at random, with stretches of steady acceptance
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = 1'b1;
			if (calm_out > 0)
				calm_out--;
			else if ($urandom_range(0, 3) == 0)
				hold_left = pick_pause();
			else if ($urandom_range(0, 149) == 0)
				calm_out = $urandom_range(40, 150);
		end
	end

	// Monitor: track settings, predict on each accepted byte, check each result
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_now = POWER_ON_SETTINGS;
			enter_idle();
			addr = 16'h0000;
			remaining = 8'd0;
			kind = KIND_REGISTER;
			byte_taken <= 1'b0;
			since_accept <= 0;
		end else begin
			byte_taken <= in_valid && in_ready;
			if (cfg_we)
				cfg_now = with_setting(cfg_now, cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				parse_reply_byte(rx_byte);
				since_accept <= 0;
			end else if (since_accept < 1000) begin
				since_accept <= since_accept + 1;
			end
			if (out_valid && out_ready)
				check_payload();
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned random_start;
		int unsigned phase_start;
		int unsigned r;
		logic        k;

		// Power-on settings: extreme addresses, smallest payloads
		queue_frame(KIND_REGISTER, 16'h0000, 8'd1, FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'hFFFF, 8'd1, FULL_FRAME);
		// Empty and oversized counts drop the frame
		queue_frame(KIND_REGISTER, 16'h0011, 8'd0, FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'h2233, 8'd0, FULL_FRAME);
		queue_frame(KIND_REGISTER, 16'h0044, 8'(BUFFER_BYTES + 1), FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'h5566, 8'(BUFFER_BYTES / 2 + 1), FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'h7788, 8'd255, FULL_FRAME);
		// Longest payload walks the index through all its bits
		queue_frame(KIND_REGISTER, 16'h00FF, 8'(BUFFER_BYTES), FULL_FRAME);
		// Repeated first header falls back to idle, then an unknown command
		queue_byte(plan_cfg.header_first);
		queue_byte(plan_cfg.header_first);
		queue_byte(plan_cfg.header_second);
		queue_byte(8'h03);
		queue_byte(plan_cfg.register_read_code);
		queue_byte(plan_cfg.header_first);
		queue_byte(plan_cfg.header_second);
		queue_byte(8'h04);
		queue_byte(8'h00);
		queue_frame(KIND_VARIABLE, 16'h1234, 8'd2, FULL_FRAME);
		// Equal command codes decode as a register read
		queue_setting(CFG_REG_READ_CODE, plan_cfg.variable_read_code);
		queue_frame(KIND_REGISTER, 16'h0042, 8'd2, FULL_FRAME);
		queue_setting(CFG_REG_READ_CODE, 8'h81);
		// Short framing: variable reads only, second header rejected
		queue_setting(CFG_SHORT_FRAMING, 8'h01);
		queue_frame(KIND_VARIABLE, 16'hA55A, 8'd3, FULL_FRAME);
		queue_frame(KIND_REGISTER, 16'h0001, 8'd1, FULL_FRAME);
		queue_byte(plan_cfg.header_first);
		queue_byte(plan_cfg.header_second);
		// Switch to long framing right after the first header
		queue_byte(plan_cfg.header_first);
		queue_setting(CFG_SHORT_FRAMING, 8'hFE);
		queue_byte(plan_cfg.header_second);
		queue_byte(8'h00);
		queue_byte(plan_cfg.variable_read_code);
		queue_byte(8'hBE);
		queue_byte(8'hEF);
		queue_byte(8'd1);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		// Switch to short framing before the command: both codes still accepted
		queue_byte(plan_cfg.header_first);
		queue_byte(plan_cfg.header_second);
		queue_byte(8'hFF);
		queue_setting(CFG_SHORT_FRAMING, 8'h01);
		queue_byte(plan_cfg.register_read_code);
		queue_byte(8'h7E);
		queue_byte(8'd2);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_setting(CFG_SHORT_FRAMING, 8'h00);
		// Extreme settings, and a write to an index with no register
		queue_setting(CFG_HEADER_FIRST, 8'h00);
		queue_setting(CFG_HEADER_SECOND, 8'hFF);
		queue_setting(CFG_REG_READ_CODE, 8'h00);
		queue_setting(CFG_VAR_READ_CODE, 8'hFF);
		queue_setting(CFG_UNUSED_INDEX, 8'hFF);
		queue_frame(KIND_REGISTER, 16'h00AB, 8'd2, FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'hCDEF, 8'd1, FULL_FRAME);
		queue_setting(CFG_HEADER_FIRST, 8'hFF);
		queue_setting(CFG_HEADER_SECOND, 8'h00);
		queue_setting(CFG_REG_READ_CODE, 8'hFF);
		queue_setting(CFG_VAR_READ_CODE, 8'h00);
		queue_frame(KIND_REGISTER, 16'h0080, 8'd1, FULL_FRAME);
		queue_frame(KIND_VARIABLE, 16'h8001, 8'd2, FULL_FRAME);

		// Random part: mostly whole frames, some noise and cut-off frames
		random_start = bytes_queued;
		phase_start = bytes_queued;
		queue_random_settings();
		while (bytes_queued - random_start < RANDOM_BYTES) begin
			if (bytes_queued - phase_start >= PHASE_BYTES) begin
				phase_start = bytes_queued;
				queue_random_settings();
			end
			if (plan_cfg.short_framing)
				k = ($urandom_range(0, 9) == 0) ? KIND_REGISTER : KIND_VARIABLE;
			else
				k = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 78) begin
				queue_frame(k, pick_address(), pick_count(k), FULL_FRAME);
			end else if (r < 89) begin
				repeat ($urandom_range(1, 6))
					queue_byte(8'($urandom_range(0, 255)));
			end else begin
				queue_frame(k, pick_address(), pick_count(k), $urandom_range(1, 6));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all stimulus taken, all results seen, then a short settle
		@(negedge clk);
		while (link_plan.size() > 0 || in_valid || due_payload.size() > 0 || out_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES + 2) @(negedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lsrf_pkg.sv
rtl/lsrf_cfg_regs.sv
rtl/lsrf_parser.sv
rtl/lsrf_out_reg.sv
rtl/lcd_serial_reply_frame_parser.sv
dv/lcd_serial_reply_frame_parser_test.sv
